// File: sv/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, constants and helper functions of the two-link IK core.
// ----------------------------------------------------------------------------
package tlik_pkg;

	localparam int COORD_WIDTH       = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int VEC_W             = 38;   // cordic x/y datapath
	localparam int ANG_W             = 34;   // binary angle, 2^32 = one turn
	localparam int ZDIFF_W           = 35;   // angle difference into conversion

	localparam logic [15:0] LINK_RESET = 16'd1536;

	// configuration register indexes
	localparam logic REG_LINK1 = 1'b0;
	localparam logic REG_LINK2 = 1'b1;

	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
	// 2*pi in Q28, turns binary angle into Q4.12 radians after >> 48
	localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] foot_x;
		logic signed [COORD_WIDTH-1:0] foot_y;
		logic signed [COORD_WIDTH-1:0] base_x;
		logic signed [COORD_WIDTH-1:0] base_y;
	} target_t;

	typedef struct packed {
		logic signed [15:0] hip_angle;
		logic signed [15:0] knee_angle;
	} joint_t;

	typedef struct packed {
		logic                    zero;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} cvec_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
		logic [31:0] v;
		unique case (i)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051D;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2F9;
			15: v = 32'h0000517C;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A2F;
			19: v = 32'h00000517;
			20: v = 32'h0000028B;
			21: v = 32'h00000145;
			22: v = 32'h000000A2;
			23: v = 32'h00000051;
			24: v = 32'h00000028;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000002;
			29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return $signed({2'b00, v});
	endfunction

	// flag the null vector and rotate the left half plane by a quarter turn
	function automatic cvec_t cordic_prep(input logic signed [VEC_W-1:0] x,
			input logic signed [VEC_W-1:0] y);
		cvec_t v;
		v.zero = (x == '0) && (y == '0);
		v.x    = x;
		v.y    = y;
		v.z    = '0;
		if (x < 0) begin
			if (y >= 0) begin
				v.x = y;
				v.y = -x;
				v.z = QUARTER_TURN;
			end else begin
				v.x = -y;
				v.y = x;
				v.z = -QUARTER_TURN;
			end
		end
		return v;
	endfunction

endpackage

// File: sv/tlik_div_cell.sv
// ----------------------------------------------------------------------------
// tlik_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module tlik_div_cell #(
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [32:0]      den,
	input  logic [32:0]      rem_in,
	input  logic [15:0]      quo_in,
	input  logic [TAG_W-1:0] tag_in,
	output logic [32:0]      rem_out,
	output logic [15:0]      quo_out,
	output logic [TAG_W-1:0] tag_out
);
	logic [33:0] trial;
	logic        ge;
	logic [33:0] diff;
	logic [32:0] rem_s1;
	logic [15:0] quo_s1;
	logic [TAG_W-1:0] tag_s1;

	always_comb begin
		trial = {rem_in, 1'b0};
		ge    = trial >= {1'b0, den};
		diff  = trial - {1'b0, den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? diff[32:0] : trial[32:0];
			quo_s1 <= {quo_in[14:0], ge};
			tag_s1 <= tag_in;
		end
	end

	assign rem_out = rem_s1;
	assign quo_out = quo_s1;
	assign tag_out = tag_s1;

endmodule

// File: sv/tlik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tlik_sqrt_cell
// One digit of a restoring integer square root: two radicand bits per cell.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell #(
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [19:0]      rem_in,
	input  logic [16:0]      root_in,
	input  logic [33:0]      rad_in,
	input  logic [TAG_W-1:0] tag_in,
	output logic [19:0]      rem_out,
	output logic [16:0]      root_out,
	output logic [33:0]      rad_out,
	output logic [TAG_W-1:0] tag_out
);
	logic [21:0] acc;
	logic [21:0] trial;
	logic        ge;
	logic [21:0] diff;
	logic [19:0] rem_s1;
	logic [16:0] root_s1;
	logic [33:0] rad_s1;
	logic [TAG_W-1:0] tag_s1;

	always_comb begin
		acc   = {rem_in, rad_in[33:32]};
		trial = {3'b000, root_in, 2'b01};
		ge    = acc >= trial;
		diff  = acc - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? diff[19:0] : acc[19:0];
			root_s1 <= {root_in[15:0], ge};
			rad_s1  <= {rad_in[31:0], 2'b00};
			tag_s1  <= tag_in;
		end
	end

	assign rem_out  = rem_s1;
	assign root_out = root_s1;
	assign rad_out  = rad_s1;
	assign tag_out  = tag_s1;

endmodule

// File: sv/tlik_cordic_cell.sv
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// One vectoring CORDIC micro-rotation with its angle table entry.
// ----------------------------------------------------------------------------
module tlik_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic            clk,
	input  logic            en,
	input  tlik_pkg::cvec_t vin,
	output tlik_pkg::cvec_t vout
);
	import tlik_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN = atan_entry(STAGE);

	logic signed [VEC_W-1:0] xs;
	logic signed [VEC_W-1:0] ys;
	cvec_t nxt;
	cvec_t v_s1;

	always_comb begin
		xs       = vin.x >>> STAGE;
		ys       = vin.y >>> STAGE;
		nxt.zero = vin.zero;
		if (vin.y > 0) begin
			nxt.x = vin.x + ys;
			nxt.y = vin.y - xs;
			nxt.z = vin.z + ATAN;
		end else begin
			nxt.x = vin.x - ys;
			nxt.y = vin.y + xs;
			nxt.z = vin.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= nxt;
		end
	end

	assign vout = v_s1;

endmodule

// File: sv/tlik_angle_conv.sv
// ----------------------------------------------------------------------------
// tlik_angle_conv
// Binary angle to Q4.12 radians, round half away from zero, saturating.
// ----------------------------------------------------------------------------
module tlik_angle_conv (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [tlik_pkg::ZDIFF_W-1:0] z,
	output logic signed [15:0]                 ang
);
	import tlik_pkg::*;

	logic [ZDIFF_W-1:0] mag;
	logic               neg_s1;
	logic [47:0]        plo_s1;
	logic [48:0]        phi_s1;
	logic [66:0]        sum;
	logic [18:0]        r;
	logic [15:0]        res;
	logic signed [15:0] ang_s2;

	assign mag = z[ZDIFF_W-1] ? ZDIFF_W'(-z) : ZDIFF_W'(z);

	// split product keeps each multiplier near 18 x 31
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= z[ZDIFF_W-1];
			plo_s1 <= mag[16:0] * TWO_PI_Q28;
			phi_s1 <= mag[34:17] * TWO_PI_Q28;
		end
	end

	always_comb begin
		sum = {1'b0, phi_s1, 17'h0} + {19'h0, plo_s1} + (67'd1 << 47);
		r   = sum[66:48];
		if (neg_s1) begin
			res = (r > 19'd32768) ? 16'h8000 : 16'(-r);
		end else begin
			res = (r > 19'd32767) ? 16'h7FFF : r[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s2 <= $signed(res);
		end
	end

	assign ang = ang_s2;

endmodule

// File: sv/two_link_inverse_kinematics_core.sv
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_core
// Elbow-down joint angles of a two-link planar arm, one target per clock while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   target channel (target_valid/target_stall/target) carries a foot and a
//   base position in Q6.10; joint channel (joint_valid/joint_stall/joint)
//   returns hip and knee angles in Q4.12 radians, one result per transaction.
//   cfg channel writes link lengths (index 0 link 1, index 1 link 2), Q6.10;
//   cfg_ready is always high, write only while no transaction is in flight.
// Throughput: one transaction per cycle unless joint_stall holds the chain;
//   the chain is a row of cells (16 divider cells, 17 square-root cells,
//   CORDIC_STAGES cordic cells per angle) each moving its data one step on
//   every clock on which the chain is not stalled.
// Stall: while joint_valid and joint_stall are high the whole chain holds,
//   and target_stall is raised in the same cycle.
// Reset: arst_n clears all valid bits and loads both link lengths to 1.5.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_core #(
	parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              target_valid,
	output logic              target_stall,
	input  tlik_pkg::target_t target,
	output logic              joint_valid,
	input  logic              joint_stall,
	output tlik_pkg::joint_t  joint,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);
	import tlik_pkg::*;

	localparam int DIV_CELLS  = 16;
	localparam int SQRT_CELLS = 17;
	localparam int LAT        = 43 + CORDIC_STAGES;
	localparam int DTAG_W     = 37;
	localparam int STAG_W     = 52;

	logic [15:0] link1_q, link2_q;
	logic [31:0] a1sq_q, a2sq_q, a12_q;
	logic [LAT-1:0] vld_q;
	logic adv;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link1_q <= LINK_RESET;
			link2_q <= LINK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINK1: link1_q <= cfg_data;
				REG_LINK2: link2_q <= cfg_data;
			endcase
		end
	end

	// link products follow the registers in the next cycle
	always_ff @(posedge clk) begin
		a1sq_q <= link1_q * link1_q;
		a2sq_q <= link2_q * link2_q;
		a12_q  <= link1_q * link2_q;
	end

	// flow control
	assign adv          = !vld_q[LAT-1] || !joint_stall;
	assign target_stall = !adv;
	assign joint_valid  = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], target_valid && !target_stall};
		end
	end

	// s1: offsets from base
	logic signed [16:0] dx_s1, dy_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 17'(target.foot_x) - 17'(target.base_x);
			dy_s1 <= 17'(target.foot_y) - 17'(target.base_y);
		end
	end

	// s2: squares
	logic signed [16:0] dx_s2, dy_s2;
	logic signed [33:0] dxsq_s2, dysq_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dxsq_s2 <= dx_s1 * dx_s1;
			dysq_s2 <= dy_s1 * dy_s1;
		end
	end

	// s3: law of cosines numerator, clamp decisions
	logic signed [34:0] num, den;
	logic [34:0] num_abs;
	logic signed [16:0] dx_s3, dy_s3;
	logic [32:0] mag_s3;
	logic neg_s3, cpos_s3, cneg_s3;

	always_comb begin
		num = 35'(dxsq_s2) + 35'(dysq_s2) - $signed({3'b000, a1sq_q})
			- $signed({3'b000, a2sq_q});
		den = $signed({2'b00, a12_q, 1'b0});
		num_abs = num[34] ? 35'(-num) : 35'(num);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			mag_s3  <= num_abs[32:0];
			neg_s3  <= num[34];
			cpos_s3 <= num >= den;
			cneg_s3 <= num <= -den;
		end
	end

	// divider chain: |num| * 2^16 / den
	logic [32:0] den_w;
	logic [32:0] drem [0:DIV_CELLS];
	logic [15:0] dquo [0:DIV_CELLS];
	logic [DTAG_W-1:0] dtag [0:DIV_CELLS];

	assign den_w   = {a12_q, 1'b0};
	assign drem[0] = mag_s3;
	assign dquo[0] = '0;
	assign dtag[0] = {dx_s3, dy_s3, neg_s3, cpos_s3, cneg_s3};

	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
		tlik_div_cell #(.TAG_W(DTAG_W)) u_cell (
			.clk    (clk),
			.en     (adv),
			.den    (den_w),
			.rem_in (drem[k]),
			.quo_in (dquo[k]),
			.tag_in (dtag[k]),
			.rem_out(drem[k+1]),
			.quo_out(dquo[k+1]),
			.tag_out(dtag[k+1])
		);
	end

	// s4: elbow cosine in Q.16
	logic signed [16:0] dx_s4, dy_s4, dxd, dyd;
	logic signed [17:0] d_s4, dnext;
	logic dneg, dcpos, dcneg;

	always_comb begin
		{dxd, dyd, dneg, dcpos, dcneg} = dtag[DIV_CELLS];
		priority if (dcpos) begin
			dnext = 18'sd65536;
		end else if (dcneg) begin
			dnext = -18'sd65536;
		end else if (dneg) begin
			dnext = -$signed({2'b00, dquo[DIV_CELLS]});
		end else begin
			dnext = $signed({2'b00, dquo[DIV_CELLS]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s4 <= dxd;
			dy_s4 <= dyd;
			d_s4  <= dnext;
		end
	end

	// s5: cosine squared
	logic signed [16:0] dx_s5, dy_s5;
	logic signed [17:0] d_s5;
	logic signed [35:0] dsq_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s5  <= dx_s4;
			dy_s5  <= dy_s4;
			d_s5   <= d_s4;
			dsq_s5 <= d_s4 * d_s4;
		end
	end

	// square root chain: sine = floor(sqrt(2^32 - d^2))
	logic [19:0] srem [0:SQRT_CELLS];
	logic [16:0] sroot [0:SQRT_CELLS];
	logic [33:0] srad [0:SQRT_CELLS];
	logic [STAG_W-1:0] stag [0:SQRT_CELLS];

	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign srad[0]  = 34'h1_0000_0000 - dsq_s5[33:0];
	assign stag[0]  = {dx_s5, dy_s5, d_s5};

	for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
		tlik_sqrt_cell #(.TAG_W(STAG_W)) u_cell (
			.clk     (clk),
			.en      (adv),
			.rem_in  (srem[k]),
			.root_in (sroot[k]),
			.rad_in  (srad[k]),
			.tag_in  (stag[k]),
			.rem_out (srem[k+1]),
			.root_out(sroot[k+1]),
			.rad_out (srad[k+1]),
			.tag_out (stag[k+1])
		);
	end

	// s6: offset vector products
	logic signed [16:0] dx_s6, dy_s6;
	logic signed [17:0] d_s6;
	logic [16:0] s_s6;
	logic [32:0] a2s_s6;
	logic signed [34:0] a2d_s6;
	logic signed [17:0] d_sq;

	assign d_sq = stag[SQRT_CELLS][17:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s6  <= stag[SQRT_CELLS][51:35];
			dy_s6  <= stag[SQRT_CELLS][34:18];
			d_s6   <= d_sq;
			s_s6   <= sroot[SQRT_CELLS];
			a2s_s6 <= link2_q * sroot[SQRT_CELLS];
			a2d_s6 <= $signed({1'b0, link2_q}) * d_sq;
		end
	end

	// s7: cordic inputs, half-plane fold
	logic signed [VEC_W-1:0] bx, by, kx, ky, ox, oy;
	cvec_t bvec [0:CORDIC_STAGES];
	cvec_t kvec [0:CORDIC_STAGES];
	cvec_t ovec [0:CORDIC_STAGES];
	cvec_t bvec_s7, kvec_s7, ovec_s7;

	always_comb begin
		bx = VEC_W'(dx_s6) <<< 16;
		by = VEC_W'(dy_s6) <<< 16;
		kx = VEC_W'(d_s6) <<< 16;
		ky = VEC_W'($signed({1'b0, s_s6})) <<< 16;
		ox = (VEC_W'($signed({1'b0, link1_q})) <<< 16) + VEC_W'(a2d_s6);
		oy = VEC_W'($signed({1'b0, a2s_s6}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bvec_s7 <= cordic_prep(bx, by);
			kvec_s7 <= cordic_prep(kx, ky);
			ovec_s7 <= cordic_prep(ox, oy);
		end
	end

	assign bvec[0] = bvec_s7;
	assign kvec[0] = kvec_s7;
	assign ovec[0] = ovec_s7;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		tlik_cordic_cell #(.STAGE(k)) u_bearing (
			.clk (clk),
			.en  (adv),
			.vin (bvec[k]),
			.vout(bvec[k+1])
		);
		tlik_cordic_cell #(.STAGE(k)) u_knee (
			.clk (clk),
			.en  (adv),
			.vin (kvec[k]),
			.vout(kvec[k+1])
		);
		tlik_cordic_cell #(.STAGE(k)) u_offset (
			.clk (clk),
			.en  (adv),
			.vin (ovec[k]),
			.vout(ovec[k+1])
		);
	end

	// s8: hip = bearing - offset, null vectors read as zero angle
	logic signed [ANG_W-1:0] bz, kz, oz;
	logic signed [ZDIFF_W-1:0] hipz_s8, kneez_s8;

	always_comb begin
		bz = bvec[CORDIC_STAGES].zero ? '0 : bvec[CORDIC_STAGES].z;
		kz = kvec[CORDIC_STAGES].zero ? '0 : kvec[CORDIC_STAGES].z;
		oz = ovec[CORDIC_STAGES].zero ? '0 : ovec[CORDIC_STAGES].z;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hipz_s8  <= ZDIFF_W'(bz) - ZDIFF_W'(oz);
			kneez_s8 <= ZDIFF_W'(kz);
		end
	end

	logic signed [15:0] hip_ang, knee_ang;

	tlik_angle_conv u_hip_conv (
		.clk(clk),
		.en (adv),
		.z  (hipz_s8),
		.ang(hip_ang)
	);

	tlik_angle_conv u_knee_conv (
		.clk(clk),
		.en (adv),
		.z  (kneez_s8),
		.ang(knee_ang)
	);

	assign joint.hip_angle  = hip_ang;
	assign joint.knee_angle = knee_ang;

	// a stalled result must freeze the input side
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		joint_valid && joint_stall |-> target_stall)
		else $error("target accepted while result stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		target_valid && !target_stall |=> vld_q[0])
		else $error("accepted transaction lost at pipe entry");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("valid chain moved while stalled");

endmodule
